>>> rtl/wlsa_pkg.sv
// Package: shared types, constants and the logit ROM builder for the score accumulator.
`timescale 1ns / 1ps
package wlsa_pkg;

    localparam int ZONE_COUNT        = 5;
    localparam int COUNTER_WIDTH     = 32;
    localparam int LOGIT_TABLE_DEPTH = 1024;
    localparam int LOGIT_ADDR_W      = $clog2(LOGIT_TABLE_DEPTH);

    localparam int PROB_W      = 17;
    localparam int LOGIT_W     = 16;
    localparam int ACC_W       = 48;
    localparam int RANK_W      = 24;
    localparam int RCODE_W     = 4;
    localparam int ZONE_W      = 3;
    localparam int BOUND_COUNT = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [PROB_W-1:0]  PROB_ONE = 17'd65536;
    localparam logic [RCODE_W-1:0] NX_RCODE = 4'd3;
    localparam logic [ZONE_W-1:0]  ZONE_IDX_MAX = ZONE_W'(ZONE_COUNT - 1);
    localparam logic [PROB_W-1:0]  ZONE_BOUNDS [BOUND_COUNT] =
        '{17'd6554, 17'd16384, 17'd32768, 17'd58983};

    localparam logic [1:0] WIN_QUERIES   = 2'd0;
    localparam logic [1:0] WIN_RESPONSES = 2'd1;
    localparam logic [1:0] WIN_BOTH      = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_MODE    = 3'd0,
        CFG_NX_INCREMENT   = 3'd1,
        CFG_WL_RANK_LIMIT  = 3'd2,
        CFG_WL_LOGIT       = 3'd3,
        CFG_POS_LIMIT      = 3'd4,
        CFG_NEG_LIMIT      = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_PREP   = 2'd1,
        S_READ   = 2'd2,
        S_UPDATE = 2'd3
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic prep;
        logic rom_rd;
        logic update;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_ctrl_sts;

    typedef logic signed [LOGIT_W-1:0] t_logit_table [LOGIT_TABLE_DEPTH];

    // log2 in Q16: integer part from the leading one, fraction by repeated squaring
    function automatic logic [31:0] log2_q16(input logic [63:0] x);
        logic [63:0] m;
        logic [31:0] e;
        logic [15:0] frac;
        e    = 32'd0;
        frac = 16'd0;
        for (int b = 0; b < 64; b++) begin
            if (x[b]) begin
                e = 32'(b);
            end
        end
        m = x << (32'd30 - e);
        for (int k = 0; k < 16; k++) begin
            m    = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {e[15:0], frac};
    endfunction

    function automatic t_logit_table build_logit_table();
        t_logit_table tab;
        logic [63:0] a;
        logic [63:0] b;
        logic signed [63:0] d;
        logic [63:0] mag;
        logic signed [63:0] r;
        for (int i = 0; i < LOGIT_TABLE_DEPTH; i++) begin
            a   = 64'(2 * i + 1);
            b   = 64'(2 * LOGIT_TABLE_DEPTH) - a;
            d   = (signed'({32'd0, log2_q16(a)}) - signed'({32'd0, log2_q16(b)})) * 64'sd45426;
            mag = (d < 0) ? 64'(-d) : 64'(d);
            mag = (mag + (64'd1 << 23)) >> 24;
            if (mag > 64'd32768) begin
                mag = 64'd32768;
            end
            r = (d < 0) ? -signed'(mag) : signed'(mag);
            if (r > 64'sd32767) begin
                r = 64'sd32767;
            end
            tab[i] = r[LOGIT_W-1:0];
        end
        return tab;
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
        return (&c) ? c : c + COUNTER_WIDTH'(1);
    endfunction

endpackage

>>> rtl/wlsa_if.sv
// Interfaces: message input channel and result output channel.
`timescale 1ns / 1ps
interface wlsa_in_if import wlsa_pkg::*;;
    logic                valid;
    logic                ready;
    logic                is_reply;
    logic [PROB_W-1:0]   score;
    logic [RCODE_W-1:0]  response_code;
    logic [RANK_W-1:0]   popularity_rank;

    modport source(output valid, is_reply, score, response_code, popularity_rank,
                   input ready);
    modport sink(input valid, is_reply, score, response_code, popularity_rank,
                 output ready);
endinterface

interface wlsa_out_if import wlsa_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [ZONE_W-1:0]           zone_index;
    logic signed [LOGIT_W-1:0]   item_logit;
    logic [COUNTER_WIDTH-1:0]    message_count;
    logic signed [ACC_W-1:0]     logit_total;
    logic [COUNTER_WIDTH-1:0]    whitelisted_count;
    logic [COUNTER_WIDTH-1:0]    zone0_count;
    logic [COUNTER_WIDTH-1:0]    zone1_count;
    logic [COUNTER_WIDTH-1:0]    zone2_count;
    logic [COUNTER_WIDTH-1:0]    zone3_count;
    logic [COUNTER_WIDTH-1:0]    zone4_count;

    modport source(output valid, accepted, zone_index, item_logit, message_count,
                   logit_total, whitelisted_count, zone0_count, zone1_count,
                   zone2_count, zone3_count, zone4_count,
                   input ready);
    modport sink(input valid, accepted, zone_index, item_logit, message_count,
                 logit_total, whitelisted_count, zone0_count, zone1_count,
                 zone2_count, zone3_count, zone4_count,
                 output ready);
endinterface

>>> rtl/windowed_logit_score_accumulator.sv
// A result is registered after its message passes the prep, ROM read and update steps.
// The sequencer handles one message at a time and the logit ROM read is registered.
// A stalled result holds the update step.
// A new message transfer is taken while the previous result still waits.
// Reset (i_rst_n low, synchronous): counters and logit total cleared, config to defaults.
`timescale 1ns / 1ps
module windowed_logit_score_accumulator import wlsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wlsa_in_if.sink                i_in,
    wlsa_out_if.source             o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    wlsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    wlsa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

>>> rtl/wlsa_ctrl.sv
// Controller: sequences one message through prepare, ROM read and counter update.
`timescale 1ns / 1ps
module wlsa_ctrl import wlsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // no transfer while reset is held
                o_cmd.in_ready = i_rst_n;
                if (i_rst_n && i_sts.in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                // hold here while the previous result has not been taken
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/wlsa_datapath.sv
// Datapath: config registers, probability prep, logit ROM, saturating counters, result register.
`timescale 1ns / 1ps
module wlsa_datapath import wlsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wlsa_in_if.sink                i_in,
    wlsa_out_if.source             o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_ctrl_cmd              i_cmd,
    output t_ctrl_sts              o_sts
);

    localparam t_logit_table LogitRom = build_logit_table();

    // configuration
    logic [1:0]                r_window_mode;
    logic [PROB_W-1:0]         r_nx_increment;
    logic [RANK_W-1:0]         r_wl_rank_limit;
    logic signed [LOGIT_W-1:0] r_wl_logit;
    logic signed [LOGIT_W-1:0] r_pos_limit;
    logic signed [LOGIT_W-1:0] r_neg_limit;

    // captured message
    logic                      r_is_resp;
    logic [PROB_W-1:0]         r_score;
    logic [RCODE_W-1:0]        r_rcode;
    logic [RANK_W-1:0]         r_rank;

    // prepared values
    logic                      r_acc;
    logic                      r_wl;
    logic                      r_p_one;
    logic                      r_p_zero;
    logic [LOGIT_ADDR_W-1:0]   r_rom_addr;
    logic [ZONE_W-1:0]         r_zone;
    logic signed [LOGIT_W-1:0] r_rom_data;

    // state
    logic [COUNTER_WIDTH-1:0]  r_msg_cnt;
    logic [COUNTER_WIDTH-1:0]  r_wl_cnt;
    logic [COUNTER_WIDTH-1:0]  r_zone_cnt [ZONE_COUNT];
    logic signed [ACC_W-1:0]   r_acc_sum;

    // result register
    logic                      r_out_valid;
    logic                      r_out_accepted;
    logic [ZONE_W-1:0]         r_out_zone;
    logic signed [LOGIT_W-1:0] r_out_logit;

    logic [PROB_W-1:0]         w_p_clip;
    logic [PROB_W:0]           w_p_nx;
    logic [PROB_W-1:0]         w_p;
    logic [PROB_W-1:0]         w_p_eff;
    logic                      w_accept;
    logic                      w_wl;
    logic [ZONE_W-1:0]         w_zone;
    logic [15+LOGIT_ADDR_W:0]  w_idx_prod;
    logic signed [LOGIT_W-1:0] w_logit;
    logic signed [ACC_W:0]     w_sum;
    logic signed [ACC_W-1:0]   n_acc_sum;
    logic                      w_out_free;

    assign w_out_free      = !r_out_valid || o_out.ready;
    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.out_free  = w_out_free;
    assign i_in.ready      = i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode   <= WIN_BOTH;
            r_nx_increment  <= '0;
            r_wl_rank_limit <= '0;
            r_wl_logit      <= '0;
            r_pos_limit     <= 16'sd32767;
            r_neg_limit     <= -16'sd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_MODE:   r_window_mode   <= i_cfg_data[1:0];
                CFG_NX_INCREMENT:  r_nx_increment  <= i_cfg_data[PROB_W-1:0];
                CFG_WL_RANK_LIMIT: r_wl_rank_limit <= i_cfg_data[RANK_W-1:0];
                CFG_WL_LOGIT:      r_wl_logit      <= i_cfg_data[LOGIT_W-1:0];
                CFG_POS_LIMIT:     r_pos_limit     <= i_cfg_data[LOGIT_W-1:0];
                CFG_NEG_LIMIT:     r_neg_limit     <= i_cfg_data[LOGIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_resp <= i_in.is_reply;
            r_score   <= i_in.score;
            r_rcode   <= i_in.response_code;
            r_rank    <= i_in.popularity_rank;
        end
    end

    // probability prep: clip, NXDOMAIN raise, clip again, window accept, whitelist, zone, ROM index
    always_comb begin
        w_p_clip = (r_score > PROB_ONE) ? PROB_ONE : r_score;
        w_p_nx   = {1'b0, w_p_clip} + {1'b0, r_nx_increment};
        w_p      = w_p_clip;
        if (r_nx_increment != '0 && r_rcode == NX_RCODE) begin
            w_p = (w_p_nx > {1'b0, PROB_ONE}) ? PROB_ONE : w_p_nx[PROB_W-1:0];
        end
        case (r_window_mode)
            WIN_QUERIES:   w_accept = !r_is_resp;
            WIN_RESPONSES: w_accept = r_is_resp;
            default:       w_accept = 1'b1;
        endcase
        w_wl    = (r_rank != '0) && (r_rank < r_wl_rank_limit);
        w_p_eff = w_wl ? '0 : w_p;
        w_zone  = '0;
        for (int z = 0; z < BOUND_COUNT; z++) begin
            if (w_p_eff >= ZONE_BOUNDS[z]) begin
                w_zone = w_zone + ZONE_W'(1);
            end
        end
        if (w_zone > ZONE_IDX_MAX) begin
            w_zone = ZONE_IDX_MAX;
        end
        w_idx_prod = (16+LOGIT_ADDR_W)'(w_p[15:0]) * (16+LOGIT_ADDR_W)'(LOGIT_TABLE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_acc      <= w_accept;
            r_wl       <= w_wl;
            r_p_one    <= (w_p == PROB_ONE);
            r_p_zero   <= (w_p == '0);
            r_rom_addr <= w_idx_prod[16 +: LOGIT_ADDR_W];
            r_zone     <= w_zone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_rd) begin
            r_rom_data <= LogitRom[r_rom_addr];
        end
    end

    // logit select and saturating accumulate
    always_comb begin
        if (!r_acc) begin
            w_logit = '0;
        end else if (r_wl) begin
            w_logit = r_wl_logit;
        end else if (r_p_one) begin
            w_logit = r_pos_limit;
        end else if (r_p_zero) begin
            w_logit = r_neg_limit;
        end else begin
            w_logit = r_rom_data;
        end
        w_sum = {r_acc_sum[ACC_W-1], r_acc_sum} + (ACC_W+1)'(w_logit);
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            n_acc_sum = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc_sum = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_cnt <= '0;
            r_wl_cnt  <= '0;
            r_acc_sum <= '0;
            for (int z = 0; z < ZONE_COUNT; z++) begin
                r_zone_cnt[z] <= '0;
            end
        end else if (i_cmd.update && r_acc) begin
            r_msg_cnt <= sat_inc(r_msg_cnt);
            r_acc_sum <= n_acc_sum;
            if (r_wl) begin
                r_wl_cnt <= sat_inc(r_wl_cnt);
            end
            for (int z = 0; z < ZONE_COUNT; z++) begin
                if (r_zone == ZONE_W'(z)) begin
                    r_zone_cnt[z] <= sat_inc(r_zone_cnt[z]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_accepted <= r_acc;
            r_out_zone     <= r_acc ? r_zone : '0;
            r_out_logit    <= w_logit;
        end
    end

    // counters only move on an update, which also loads the result register
    assign o_out.valid             = r_out_valid;
    assign o_out.accepted          = r_out_accepted;
    assign o_out.zone_index        = r_out_zone;
    assign o_out.item_logit        = r_out_logit;
    assign o_out.message_count     = r_msg_cnt;
    assign o_out.logit_total       = r_acc_sum;
    assign o_out.whitelisted_count = r_wl_cnt;
    assign o_out.zone0_count       = r_zone_cnt[0];
    assign o_out.zone1_count       = r_zone_cnt[1];
    assign o_out.zone2_count       = r_zone_cnt[2];
    assign o_out.zone3_count       = r_zone_cnt[3];
    assign o_out.zone4_count       = r_zone_cnt[4];

    a_wl_le_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl_cnt <= r_msg_cnt)
        else $error("whitelisted count exceeds message count");

    a_update_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> w_out_free)
        else $error("update issued while result register still occupied");

    a_msg_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_acc && !(&r_msg_cnt)) |=>
            r_msg_cnt == $past(r_msg_cnt) + COUNTER_WIDTH'(1))
        else $error("message count did not advance on accepted message");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_acc) |=> $stable(r_msg_cnt) && $stable(r_acc_sum))
        else $error("counters moved on a rejected message");

endmodule

>>> tb/tb.sv
// Testbench for the windowed logit score accumulator: directed script, then random phases.
`timescale 1ns / 1ps
module tb;
    import wlsa_pkg::*;

    localparam logic [1:0]             MODE_BOTH_ALT = 2'd3;
    localparam logic [RCODE_W-1:0]     NXDOMAIN_RCODE = 4'd3;
    localparam int                     P_FULL = 65536;
    localparam int                     ZONE_EDGE [4] = '{6554, 16384, 32768, 58983};
    localparam logic signed [15:0]     LOGIT_MIN = 16'sh8000;
    localparam logic signed [15:0]     LOGIT_MAX = 16'sh7FFF;
    localparam longint                 SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint                 SUM_MIN = -SUM_MAX - 1;
    localparam int                     IDLE_LIMIT = 2000;
    localparam int                     PHASES = 8;
    localparam int                     PHASE_ITEMS = 216;
    localparam int                     SCRIPT_ROWS = 35;

    typedef struct packed {
        logic                is_resp;
        logic [PROB_W-1:0]   score;
        logic [RCODE_W-1:0]  rcode;
        logic [RANK_W-1:0]   rank;
    } t_msg;

    typedef struct packed {
        logic                                     accepted;
        logic [ZONE_W-1:0]                        zone;
        logic signed [LOGIT_W-1:0]                logit;
        logic [COUNTER_WIDTH-1:0]                 msg_count;
        logic signed [ACC_W-1:0]                  total;
        logic [COUNTER_WIDTH-1:0]                 wl_count;
        logic [ZONE_COUNT-1:0][COUNTER_WIDTH-1:0] zone_cnt;
    } t_tally;

    typedef enum logic {ROW_MSG, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        t_cfg_index                reg_idx;
        logic [CFG_DATA_W-1:0]     reg_data;
        logic                      is_resp;
        logic [PROB_W-1:0]         score;
        logic [RCODE_W-1:0]        rcode;
        logic [RANK_W-1:0]         rank;
        logic                      typed;
        logic                      acc;
        logic [ZONE_W-1:0]         zone;
        logic signed [LOGIT_W-1:0] logit;
    } t_script_row;

    // typed columns hold accepted / zone / logit where they follow directly from the rules
    t_script_row script [SCRIPT_ROWS] = '{
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd0,      4'd0,  24'd0,        1'b1, 1'b1, 3'd0, LOGIT_MIN},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd65536,  4'd0,  24'd0,        1'b1, 1'b1, 3'd4, LOGIT_MAX},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd131071, 4'd15, 24'hFFFFFF,   1'b1, 1'b1, 3'd4, LOGIT_MAX},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd1,      4'd3,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd65535,  4'd0,  24'd1,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd6553,   4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd6554,   4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd16384,  4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd32767,  4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd58982,  4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd58983,  4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_NX_INCREMENT,  24'h010000, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_WL_RANK_LIMIT, 24'hFFFFFF, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_WL_LOGIT,      24'h008000, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_POS_LIMIT,     24'h008000, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_NEG_LIMIT,     24'h007FFF, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd1,      4'd3,  24'd0,        1'b1, 1'b1, 3'd4, LOGIT_MIN},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd0,      4'd3,  24'd0,        1'b1, 1'b1, 3'd4, LOGIT_MIN},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd0,      4'd2,  24'd0,        1'b1, 1'b1, 3'd0, LOGIT_MAX},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd65536,  4'd0,  24'd1,        1'b1, 1'b1, 3'd0, LOGIT_MIN},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd40000,  4'd3,  24'hFFFFFE,   1'b1, 1'b1, 3'd0, LOGIT_MIN},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd40000,  4'd0,  24'hFFFFFF,   1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_WINDOW_MODE, {22'd0, WIN_QUERIES}, 1'b0, 17'd0, 4'd0, 24'd0, 1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd100,    4'd0,  24'd0,        1'b1, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd100,    4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_WINDOW_MODE, {22'd0, WIN_RESPONSES}, 1'b0, 17'd0, 4'd0, 24'd0, 1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd100,    4'd0,  24'd0,        1'b1, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd30000,  4'd1,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_WINDOW_MODE, {22'd0, MODE_BOTH_ALT}, 1'b0, 17'd0, 4'd0, 24'd0, 1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b0, 17'd20000,  4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd20000,  4'd0,  24'd0,        1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_NX_INCREMENT,  24'h000001, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_CFG, CFG_WL_LOGIT,      24'h007FFF, 1'b0, 17'd0, 4'd0, 24'd0,       1'b0, 1'b0, 3'd0, 16'sd0},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd65535,  4'd3,  24'd0,        1'b1, 1'b1, 3'd4, LOGIT_MIN},
        '{ROW_MSG, CFG_WINDOW_MODE, 24'd0, 1'b1, 17'd2,      4'd0,  24'd1,        1'b1, 1'b1, 3'd0, LOGIT_MAX}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    wlsa_in_if  in_ch ();
    wlsa_out_if out_ch ();

    windowed_logit_score_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirror of the block's registers and counters
    logic signed [LOGIT_W-1:0] logit_rom [LOGIT_TABLE_DEPTH];
    logic [1:0]                cfg_mode;
    logic [PROB_W-1:0]         cfg_nx;
    logic [RANK_W-1:0]         cfg_wl_limit;
    logic signed [LOGIT_W-1:0] cfg_wl_logit;
    logic signed [LOGIT_W-1:0] cfg_pos;
    logic signed [LOGIT_W-1:0] cfg_neg;
    logic [COUNTER_WIDTH-1:0]  zone_tally [ZONE_COUNT];
    logic [COUNTER_WIDTH-1:0]  msg_tally;
    logic [COUNTER_WIDTH-1:0]  wl_tally;
    longint                    logit_sum;

    t_tally pending_tallies [$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;

    logic long_hold_req;
    bit   long_hold_done = 1'b0;
    int   rx_hold = 0;
    int   rx_cycle = 0;
    int   rx_style = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint log2_fixed(longint unsigned x);
        int             ip;
        longint unsigned mant;
        longint         fr;
        ip = 0;
        fr = 0;
        while ((x >> (ip + 1)) != 0) ip++;
        mant = x << (30 - ip);
        for (int k = 0; k < 16; k++) begin
            mant = (mant * mant) >> 30;
            fr = fr << 1;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(ip) << 16) + fr;
    endfunction

    // entry i is the logit at the midpoint of bin i, rounded half away from zero
    function automatic void build_logit_rom();
        longint a;
        longint d;
        longint mag;
        longint r;
        for (int i = 0; i < LOGIT_TABLE_DEPTH; i++) begin
            a = 2 * i + 1;
            d = (log2_fixed(a) - log2_fixed(2 * LOGIT_TABLE_DEPTH - a)) * 45426;
            mag = (d < 0) ? -d : d;
            mag = (mag + 64'sd8388608) >>> 24;
            if (mag > 32768) mag = 32768;
            r = (d < 0) ? -mag : mag;
            if (r > 32767) r = 32767;
            logit_rom[i] = 16'(r);
        end
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] bump(logic [COUNTER_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic void reset_model();
        cfg_mode = WIN_BOTH;
        cfg_nx = '0;
        cfg_wl_limit = '0;
        cfg_wl_logit = '0;
        cfg_pos = LOGIT_MAX;
        cfg_neg = LOGIT_MIN;
        foreach (zone_tally[z]) zone_tally[z] = '0;
        msg_tally = '0;
        wl_tally = '0;
        logit_sum = 0;
    endfunction

    function automatic t_tally score_message(t_msg m);
        t_tally t;
        int     p;
        int     zi;
        logic   take;
        logic signed [LOGIT_W-1:0] lg;
        take = !((cfg_mode == WIN_QUERIES && m.is_resp) ||
                 (cfg_mode == WIN_RESPONSES && !m.is_resp));
        zi = 0;
        lg = '0;
        if (take) begin
            p = (int'(m.score) > P_FULL) ? P_FULL : int'(m.score);
            if (cfg_nx != 0 && m.rcode == NXDOMAIN_RCODE) begin
                p = p + int'(cfg_nx);
                if (p > P_FULL) p = P_FULL;
            end
            if (p == P_FULL) lg = cfg_pos;
            else if (p == 0) lg = cfg_neg;
            else lg = logit_rom[(longint'(p) * LOGIT_TABLE_DEPTH) >> 16];
            if (m.rank != 0 && m.rank < cfg_wl_limit) begin
                p = 0;
                lg = cfg_wl_logit;
                wl_tally = bump(wl_tally);
            end
            msg_tally = bump(msg_tally);
            for (int b = 0; b < 4; b++)
                if (p >= ZONE_EDGE[b]) zi++;
            if (zi > ZONE_COUNT - 1) zi = ZONE_COUNT - 1;
            zone_tally[zi] = bump(zone_tally[zi]);
            logit_sum = logit_sum + longint'(lg);
            if (logit_sum > SUM_MAX) logit_sum = SUM_MAX;
            if (logit_sum < SUM_MIN) logit_sum = SUM_MIN;
        end
        t.accepted = take;
        t.zone = ZONE_W'(zi);
        t.logit = lg;
        t.msg_count = msg_tally;
        t.total = ACC_W'(logit_sum);
        t.wl_count = wl_tally;
        for (int z = 0; z < ZONE_COUNT; z++) t.zone_cnt[z] = zone_tally[z];
        return t;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] exp_v,
                                        logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // result side: compare every transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_tally t;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_tallies.size() == 0) begin
                $error("result transfer with no message outstanding");
                mismatch_count++;
            end else begin
                t = pending_tallies.pop_front();
                check_field("accepted", {63'd0, t.accepted}, {63'd0, out_ch.accepted});
                check_field("zone_index", {61'd0, t.zone}, {61'd0, out_ch.zone_index});
                check_field("item_logit", t.logit, out_ch.item_logit);
                check_field("message_count", {32'd0, t.msg_count}, {32'd0, out_ch.message_count});
                check_field("logit_total", t.total, out_ch.logit_total);
                check_field("whitelisted_count", {32'd0, t.wl_count},
                            {32'd0, out_ch.whitelisted_count});
                check_field("zone0_count", {32'd0, t.zone_cnt[0]}, {32'd0, out_ch.zone0_count});
                check_field("zone1_count", {32'd0, t.zone_cnt[1]}, {32'd0, out_ch.zone1_count});
                check_field("zone2_count", {32'd0, t.zone_cnt[2]}, {32'd0, out_ch.zone2_count});
                check_field("zone3_count", {32'd0, t.zone_cnt[3]}, {32'd0, out_ch.zone3_count});
                check_field("zone4_count", {32'd0, t.zone_cnt[4]}, {32'd0, out_ch.zone4_count});
            end
        end
    end

    // receiver stall pattern; the style is redrawn periodically, style 0 adds no stalls of its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            out_ch.ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rx_hold = 120;
            out_ch.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 256 == 0) rx_style = $urandom_range(0, 3);
            if (rx_style != 0 && $urandom_range(0, 299) == 0) begin
                rx_hold = $urandom_range(10, 40);
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_style)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: out_ch.ready <= ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("windowed_logit_score_accumulator test failed");
                $finish;
            end
        end
    end

    task automatic offer_message(input t_msg m);
        in_ch.valid <= 1'b1;
        in_ch.is_reply <= m.is_resp;
        in_ch.score <= m.score;
        in_ch.response_code <= m.rcode;
        in_ch.popularity_rank <= m.rank;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_tallies.push_back(score_message(m));
    endtask

    task automatic drain_results();
        while (pending_tallies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_WINDOW_MODE:   cfg_mode = data[1:0];
            CFG_NX_INCREMENT:  cfg_nx = data[PROB_W-1:0];
            CFG_WL_RANK_LIMIT: cfg_wl_limit = data[RANK_W-1:0];
            CFG_WL_LOGIT:      cfg_wl_logit = data[LOGIT_W-1:0];
            CFG_POS_LIMIT:     cfg_pos = data[LOGIT_W-1:0];
            CFG_NEG_LIMIT:     cfg_neg = data[LOGIT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [LOGIT_W-1:0] pick_logit();
        case ($urandom_range(0, 3))
            0: return LOGIT_MIN;
            1: return LOGIT_MAX;
            2: return '0;
            default: return LOGIT_W'($urandom);
        endcase
    endfunction

    // all six registers, with junk in the bits above each field narrower than the data bus
    task automatic pick_phase_settings(input int phase);
        logic [1:0]        mode;
        logic [PROB_W-1:0] nx;
        logic [RANK_W-1:0] lim;
        case (phase % 4)
            0: mode = WIN_QUERIES;
            1: mode = WIN_RESPONSES;
            2: mode = WIN_BOTH;
            default: mode = MODE_BOTH_ALT;
        endcase
        case ($urandom_range(0, 3))
            0: nx = '0;
            1: nx = 17'd65536;
            2: nx = 17'($urandom_range(1, 65535));
            default: nx = 17'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(0, 3))
            0: lim = '0;
            1: lim = 24'hFFFFFF;
            2: lim = 24'($urandom_range(1, 5000));
            default: lim = 24'($urandom);
        endcase
        write_reg(CFG_WINDOW_MODE, {22'($urandom), mode});
        write_reg(CFG_NX_INCREMENT, {7'($urandom), nx});
        write_reg(CFG_WL_RANK_LIMIT, lim);
        write_reg(CFG_WL_LOGIT, {8'($urandom), pick_logit()});
        write_reg(CFG_POS_LIMIT, {8'($urandom), pick_logit()});
        write_reg(CFG_NEG_LIMIT, {8'($urandom), pick_logit()});
    endtask

    function automatic t_msg random_msg();
        t_msg m;
        int   pick;
        int   thr;
        m.is_resp = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 8) m.score = '0;
        else if (pick < 14) m.score = 17'(P_FULL);
        else if (pick < 20) m.score = 17'($urandom_range(65537, 131071));
        else if (pick < 40) begin
            thr = ZONE_EDGE[$urandom_range(0, 3)] + int'($urandom_range(0, 4)) - 2;
            m.score = 17'(thr);
        end else if (pick < 50) m.score = 17'($urandom_range(0, 131071));
        else m.score = 17'($urandom_range(1, 65535));
        m.rcode = ($urandom_range(0, 9) < 3) ? NXDOMAIN_RCODE : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 35) m.rank = '0;
        else if (pick < 55) m.rank = 24'(int'(cfg_wl_limit) + int'($urandom_range(0, 6)) - 3);
        else if (pick < 75) m.rank = 24'($urandom_range(1, 5000));
        else m.rank = 24'($urandom);
        return m;
    endfunction

    initial begin
        t_msg        m;
        t_tally      t;
        t_script_row row;
        int          left;
        int          burst;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WINDOW_MODE;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.is_reply = 1'b0;
        in_ch.score = '0;
        in_ch.response_code = '0;
        in_ch.popularity_rank = '0;
        long_hold_req = 1'b0;
        build_logit_rom();
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_CFG) begin
                in_ch.valid <= 1'b0;
                drain_results();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                m = '{row.is_resp, row.score, row.rcode, row.rank};
                offer_message(m);
                if (row.typed) begin
                    t = pending_tallies.pop_back();
                    t.accepted = row.acc;
                    t.zone = row.zone;
                    t.logit = row.logit;
                    pending_tallies.push_back(t);
                end
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            in_ch.valid <= 1'b0;
            drain_results();
            pick_phase_settings(ph);
            // one long receiver hold-off while the sender keeps offering
            if (ph == 1) long_hold_req <= 1'b1;
            left = PHASE_ITEMS;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && left > 0) begin
                    offer_message(random_msg());
                    burst--;
                    left--;
                end
                if (ph % 3 != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            end
        end

        in_ch.valid <= 1'b0;
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("windowed_logit_score_accumulator test passed");
        end else begin
            $display("windowed_logit_score_accumulator test failed");
        end
        $finish;
    end

endmodule
